FILE: rtl/sliding_window_extremes_unit_assert.svh
// assertion macros for the sliding window extremes unit
// each expects clk and arst_n to be visible where it is used
`ifndef SLIDING_WINDOW_EXTREMES_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_EXTREMES_UNIT_ASSERT_SVH

// same-cycle implication
`define SWE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swe assertion failed");

// next-cycle implication
`define SWE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swe assertion failed");

`endif

FILE: rtl/swe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swe_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int AGE_W      = $clog2(WINDOW_MAX);
	localparam int LEN_W      = AGE_W + 1;
	localparam int SAMPLE_W   = 32;
	localparam int POS_W      = 6;
	localparam int CFG_W      = 7;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [AGE_W-1:0]           age_t;
	typedef logic [LEN_W-1:0]           len_t;
	typedef logic [POS_W-1:0]           pos_t;

	// per-cell shift control: shift takes a new item in, rot turns the ring
	typedef struct packed {
		logic shift;
		logic rot;
	} cell_ctl_t;

	// compare unit control
	typedef struct packed {
		logic en;     // a scan step happens this cycle
		logic first;  // newest sample, seeds the accumulators
		logic in_win; // tap lies inside the window
	} scan_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/swe_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module swe_cell import swe_pkg::*; (
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire sample_t   shift_in,
	input  wire sample_t   rot_in,
	output sample_t        q
);

	sample_t data_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= shift_in;
		end else if (ctl.rot) begin
			data_q <= rot_in;
		end
	end

	assign q = data_q;

endmodule

`default_nettype wire

FILE: rtl/swe_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module swe_scan import swe_pkg::*; (
	input  wire logic      clk,
	input  wire scan_ctl_t ctl,
	input  wire sample_t   tap,
	input  wire age_t      age,
	input  wire len_t      len,
	output sample_t        nxt_max,
	output sample_t        nxt_min,
	output pos_t           nxt_pmax,
	output pos_t           nxt_pmin
);

	sample_t max_q;
	sample_t min_q;
	pos_t    pmax_q;
	pos_t    pmin_q;
	pos_t    pos;

	// offset from the oldest window sample
	assign pos = POS_W'(len - len_t'(1) - len_t'(age));

	// walking from newest to oldest, >= / <= hand ties to the older sample
	always_comb begin
		nxt_max  = max_q;
		nxt_min  = min_q;
		nxt_pmax = pmax_q;
		nxt_pmin = pmin_q;
		if (ctl.first) begin
			nxt_max  = tap;
			nxt_min  = tap;
			nxt_pmax = pos;
			nxt_pmin = pos;
		end else if (ctl.in_win) begin
			if (tap >= max_q) begin
				nxt_max  = tap;
				nxt_pmax = pos;
			end
			if (tap <= min_q) begin
				nxt_min  = tap;
				nxt_pmin = pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			max_q  <= nxt_max;
			min_q  <= nxt_min;
			pmax_q <= nxt_pmax;
			pmin_q <= nxt_pmin;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sliding_window_extremes_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: sample; tuser: series_start
// m_*       out  m_tvalid/m_tready  tdata: window_max, window_min, max_position, min_position
// config    in   window_length_we   window_length (7 bits)
//
// an item is first shifted into the cell ring, then scanned in 64 steps
// in which the ring turns once past the single compare tap at cell 0
// a result sits in the output register while the next item is accepted and scanned;
// the last scan step waits while that register is still occupied
// arst_n clears control state, window_length resets to 1; cell contents need no reset
// cells never written are only ever looked at outside the window, so no clearing pass

module sliding_window_extremes_unit import swe_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// config write
	input  wire logic              window_length_we,
	input  wire logic [CFG_W-1:0]  window_length,
	// input items
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [31:0]       s_tdata,  // [31:0] sample
	input  wire logic              s_tuser,  // [0] series_start
	// result items
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [79:0]            m_tdata   // [31:0] window_max, [63:32] window_min,
	                                         // [69:64] max_position, [75:70] min_position
);

	state_t             state_q;
	age_t               cnt_q;
	len_t               len_q;
	len_t               fill_q;
	logic [CFG_W-1:0]   wlen_q;

	logic               accept;
	logic               scanning;
	logic               last;
	logic               out_free;
	logic               advance;
	logic               load;

	len_t               fill_base;
	len_t               fill_nxt;
	len_t               wlen_eff;
	len_t               len_nxt;

	cell_ctl_t          cell_ctl;
	scan_ctl_t          scan_ctl;
	sample_t            cell_q [WINDOW_MAX];

	sample_t            nxt_max;
	sample_t            nxt_min;
	pos_t               nxt_pmax;
	pos_t               nxt_pmin;

	logic               m_tvalid_q;
	sample_t            max_q;
	sample_t            min_q;
	pos_t               pmax_q;
	pos_t               pmin_q;

	// handshake and sequencing
	assign scanning = (state_q == ST_SCAN);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign last     = (cnt_q == age_t'(WINDOW_MAX - 1));
	assign out_free = !m_tvalid_q || m_tready;
	assign advance  = scanning && (!last || out_free);
	assign load     = advance && last;

	// window length clamp: zero means one, cap at the ring depth, then at the fill
	always_comb begin
		fill_base = s_tuser ? '0 : fill_q;
		fill_nxt  = (fill_base < len_t'(WINDOW_MAX)) ? fill_base + len_t'(1) : fill_base;
		if (wlen_q == '0) begin
			wlen_eff = len_t'(1);
		end else if ({1'b0, wlen_q} > (CFG_W + 1)'(WINDOW_MAX)) begin
			wlen_eff = len_t'(WINDOW_MAX);
		end else begin
			wlen_eff = len_t'(wlen_q);
		end
		len_nxt = (wlen_eff > fill_nxt) ? fill_nxt : wlen_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= CFG_W'(1);
		end else if (window_length_we) begin
			wlen_q <= window_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			fill_q  <= '0;
			len_q   <= len_t'(1);
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
						fill_q  <= fill_nxt;
						len_q   <= len_nxt;
					end
				end
				ST_SCAN: begin
					if (advance) begin
						cnt_q <= last ? '0 : cnt_q + age_t'(1);
						if (last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// cell ring: newest at cell 0; a shift pushes the oldest out,
	// a rotation brings the next older sample to the tap
	assign cell_ctl.shift = accept;
	assign cell_ctl.rot   = advance;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		localparam int PREV = (i == 0) ? 0 : i - 1;
		localparam int NEXT = (i + 1) % WINDOW_MAX;
		swe_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.shift_in ((i == 0) ? sample_t'(s_tdata) : cell_q[PREV]),
			.rot_in   (cell_q[NEXT]),
			.q        (cell_q[i])
		);
	end

	// compare unit at the tap; cnt_q is the age of the sample there
	assign scan_ctl.en     = advance;
	assign scan_ctl.first  = (cnt_q == '0);
	assign scan_ctl.in_win = (len_t'(cnt_q) < len_q);

	swe_scan u_scan (
		.clk      (clk),
		.ctl      (scan_ctl),
		.tap      (cell_q[0]),
		.age      (cnt_q),
		.len      (len_q),
		.nxt_max  (nxt_max),
		.nxt_min  (nxt_min),
		.nxt_pmax (nxt_pmax),
		.nxt_pmin (nxt_pmin)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			max_q  <= nxt_max;
			min_q  <= nxt_min;
			pmax_q <= nxt_pmax;
			pmin_q <= nxt_pmin;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, pmin_q, pmax_q, min_q, max_q};

	`include "sliding_window_extremes_unit_assert.svh"

	// idle always leaves the ring aligned, newest at the tap
	`SWE_ASSERT_NOW(a_idle_aligned, s_tready, cnt_q == '0)
	// window never empty, never past what the series has delivered
	`SWE_ASSERT_NOW(a_len_range, scanning, (len_q != '0) && (len_q <= fill_q))
	// finishing a scan always presents a result
	`SWE_ASSERT_NEXT(a_load_valid, load, m_tvalid)
	// an accepted item always starts a scan
	`SWE_ASSERT_NEXT(a_accept_scan, accept, scanning && (cnt_q == '0))

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import swe_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 4_000_000;
	localparam int RANDOM_ITEMS = 1350;
	localparam int SETTLE_GAP   = 4;
	localparam int DRAIN_CYCLES = 80;
	localparam int REPORT_MAX   = 10;
	localparam int N_DIRECTED   = 18;

	// one window result, in the order the fields are printed
	typedef struct packed {
		sample_t wmax;
		sample_t wmin;
		pos_t    pmax;
		pos_t    pmin;
	} extremes_t;

	// one directed row: optional window length write, then one item
	typedef struct {
		bit               set_len;
		logic [CFG_W-1:0] len_val;
		sample_t          smp;
		bit               start;
		bit               typed;
		extremes_t        want;
	} stim_row_t;

	logic               clk              = 1'b0;
	logic               arst_n           = 1'b0;
	logic               window_length_we = 1'b0;
	logic [CFG_W-1:0]   window_length    = '0;
	logic               s_tvalid         = 1'b0;
	logic               s_tready;
	logic [31:0]        s_tdata          = '0;  // [31:0] sample
	logic               s_tuser          = 1'b0; // [0] series_start
	logic               m_tvalid;
	logic               m_tready         = 1'b0;
	logic [79:0]        m_tdata;  // [31:0] window_max, [63:32] window_min,
	                              // [69:64] max_position, [75:70] min_position

	// predictor state, kept beside the block
	sample_t          ring [WINDOW_MAX];
	int unsigned      series_fill = 0;
	int unsigned      next_slot   = 0;
	logic [CFG_W-1:0] win_len_cfg = 7'd1;

	extremes_t   pending_results [$];
	int unsigned mismatches   = 0;
	int unsigned cycle_count  = 0;
	int unsigned burst_left   = 0;
	int unsigned stall_left   = 0;
	int unsigned calm_left    = 0;

	// expected results only where they follow at a glance
	stim_row_t directed_rows [N_DIRECTED] = '{
		// no series start after reset, window length 1 from reset
		'{1'b0, 7'd0,   32'sh7FFF_FFFF, 1'b0, 1'b1,
			'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 6'd0, 6'd0}},
		'{1'b0, 7'd0,   32'sh8000_0000, 1'b0, 1'b1,
			'{32'sh8000_0000, 32'sh8000_0000, 6'd0, 6'd0}},
		// zero length behaves as one
		'{1'b1, 7'd0,   32'sh0000_0000, 1'b1, 1'b1,
			'{32'sh0000_0000, 32'sh0000_0000, 6'd0, 6'd0}},
		'{1'b0, 7'd0,   32'sh0000_0009, 1'b0, 1'b1,
			'{32'sh0000_0009, 32'sh0000_0009, 6'd0, 6'd0}},
		// short series under a window of four, ties to the oldest
		'{1'b1, 7'd4,   32'sh0000_0005, 1'b1, 1'b1,
			'{32'sh0000_0005, 32'sh0000_0005, 6'd0, 6'd0}},
		'{1'b0, 7'd0,   32'sh0000_0005, 1'b0, 1'b1,
			'{32'sh0000_0005, 32'sh0000_0005, 6'd0, 6'd0}},
		'{1'b0, 7'd0,   32'shFFFF_FFFF, 1'b0, 1'b1,
			'{32'sh0000_0005, 32'shFFFF_FFFF, 6'd0, 6'd2}},
		'{1'b0, 7'd0,   32'sh7FFF_FFFF, 1'b0, 1'b1,
			'{32'sh7FFF_FFFF, 32'shFFFF_FFFF, 6'd3, 6'd2}},
		// window now slides
		'{1'b0, 7'd0,   32'sh8000_0000, 1'b0, 1'b0, '0},
		'{1'b0, 7'd0,   32'shFFFF_FFFF, 1'b0, 1'b0, '0},
		// lengths above the history depth saturate
		'{1'b1, 7'd127, 32'sh0000_0003, 1'b0, 1'b0, '0},
		'{1'b1, 7'd65,  32'shFFFF_FFFE, 1'b0, 1'b0, '0},
		// full depth, fresh series
		'{1'b1, 7'd64,  32'sh8000_0000, 1'b1, 1'b1,
			'{32'sh8000_0000, 32'sh8000_0000, 6'd0, 6'd0}},
		'{1'b0, 7'd0,   32'sh8000_0000, 1'b0, 1'b1,
			'{32'sh8000_0000, 32'sh8000_0000, 6'd0, 6'd0}},
		'{1'b0, 7'd0,   32'sh7FFF_FFFF, 1'b0, 1'b1,
			'{32'sh7FFF_FFFF, 32'sh8000_0000, 6'd2, 6'd0}},
		// shrinking the window in the middle of a series
		'{1'b1, 7'd2,   32'sh0000_0004, 1'b0, 1'b0, '0},
		'{1'b1, 7'd1,   32'shFFFF_FFFF, 1'b0, 1'b0, '0},
		'{1'b1, 7'd3,   32'sh0000_0000, 1'b0, 1'b0, '0}
	};

	sliding_window_extremes_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.window_length_we (window_length_we),
		.window_length    (window_length),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata)
	);

	always #CLK_HALF clk = ~clk;

	// store one sample and scan the window it closes
	function automatic extremes_t slide_window(input sample_t smp, input bit start);
		int unsigned span;
		int unsigned oldest;
		int unsigned k;
		sample_t     v;
		sample_t     hi;
		sample_t     lo;
		extremes_t   r;
		if (start) begin
			series_fill = 0;
		end
		ring[next_slot] = smp;
		next_slot = (next_slot + 1) % WINDOW_MAX;
		if (series_fill < WINDOW_MAX) begin
			series_fill++;
		end
		span = win_len_cfg;
		if (span == 0) begin
			span = 1;
		end
		if (span > WINDOW_MAX) begin
			span = WINDOW_MAX;
		end
		if (span > series_fill) begin
			span = series_fill;
		end
		oldest = (next_slot + WINDOW_MAX - span) % WINDOW_MAX;
		hi = ring[oldest];
		lo = hi;
		r.pmax = '0;
		r.pmin = '0;
		for (k = 1; k < span; k++) begin
			v = ring[(oldest + k) % WINDOW_MAX];
			// strict compares keep the earliest of equal values
			if (v > hi) begin
				hi = v;
				r.pmax = pos_t'(k);
			end
			if (v < lo) begin
				lo = v;
				r.pmin = pos_t'(k);
			end
		end
		r.wmax = hi;
		r.wmin = lo;
		return r;
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 32'sh0000_0000;
					default: return 32'shFFFF_FFFF;
				endcase
			end
			// narrow range makes ties common
			1, 2, 3: return sample_t'(int'($urandom_range(0, 8)) - 4);
			default: return sample_t'($urandom());
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_window();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd1;
			2: return 7'd64;
			3: return 7'($urandom_range(65, 127));
			default: return 7'($urandom_range(2, 63));
		endcase
	endfunction

	// one item, bursts of random length with random gaps between them
	task automatic push_item(input sample_t smp, input bit start, input bit typed,
			input extremes_t want);
		int unsigned gap;
		extremes_t   predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= start;
		do @(posedge clk); while (!s_tready);
		predicted = slide_window(smp, start);
		if (typed) begin
			predicted = want;
		end
		pending_results = {pending_results, predicted};
	endtask

	// hold off until every result is out, then write the window length
	task automatic set_window(input logic [CFG_W-1:0] len);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_GAP) @(posedge clk);
		window_length_we <= 1'b1;
		window_length    <= len;
		@(posedge clk);
		win_len_cfg = len;
		window_length_we <= 1'b0;
	endtask

	// receiver: mostly ready, short and long stalls, calm stretches
	always @(posedge clk) begin
		int unsigned r;
		r = $urandom_range(0, 999);
		if (calm_left > 0) begin
			calm_left--;
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (r < 3) begin
				calm_left = $urandom_range(500, 3000);
			end else if (r < 13) begin
				stall_left = $urandom_range(20, 150);
			end else if (r < 80) begin
				stall_left = $urandom_range(1, 4);
			end
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		extremes_t got;
		extremes_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.wmax = m_tdata[31:0];
			got.wmin = m_tdata[63:32];
			got.pmax = m_tdata[69:64];
			got.pmin = m_tdata[75:70];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("unexpected result: max %0d min %0d pmax %0d pmin %0d",
						got.wmax, got.wmin, got.pmax, got.pmin);
				end
			end else begin
				want = pending_results.pop_front();
				if (got.wmax != want.wmax || got.wmin != want.wmin ||
						got.pmax != want.pmax || got.pmin != want.pmin) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("expected max %0d min %0d pmax %0d pmin %0d",
							want.wmax, want.wmin, want.pmax, want.pmin,
							", got max %0d min %0d pmax %0d pmin %0d",
							got.wmax, got.wmin, got.pmax, got.pmin);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sliding_window_extremes_unit: mismatch");
			$finish;
		end
	end

	initial begin
		int unsigned sent;
		int unsigned phase_len;
		int unsigned k;
		bit          starts_on;
		bit          start;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_DIRECTED; k++) begin
			if (directed_rows[k].set_len) begin
				set_window(directed_rows[k].len_val);
			end
			push_item(directed_rows[k].smp, directed_rows[k].start,
				directed_rows[k].typed, directed_rows[k].want);
		end

		// random phases, each under its own window length
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			set_window(pick_window());
			phase_len = $urandom_range(30, 110);
			// some phases never restart so the history wraps
			starts_on = ($urandom_range(0, 2) != 0);
			for (k = 0; k < phase_len; k++) begin
				start = starts_on && ((k == 0 && $urandom_range(0, 2) == 0) ||
					$urandom_range(0, 39) == 0);
				push_item(pick_sample(), start, 1'b0, '0);
			end
			sent += phase_len;
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("sliding_window_extremes_unit: match");
		end else begin
			$display("sliding_window_extremes_unit: mismatch");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/swe_pkg.sv
rtl/swe_cell.sv
rtl/swe_scan.sv
rtl/sliding_window_extremes_unit.sv
tb/testbench.sv
